// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the ragged range gather block; each user
// module needs clk and arst_n in scope
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLKD(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLKD(lbl, !(expr), msg)

`endif

// ===== rtl/rrg_pkg.sv =====
// ----------------------------------------------------------------------------
// rrg_pkg
// Shared sizes, command and result codes, and inter-module types for the
// ragged range gather block
// ----------------------------------------------------------------------------
package rrg_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int MAX_RUN       = 64;
	localparam int POS_BITS      = 32;

	localparam int ADDR_BITS = $clog2(TABLE_ENTRIES);
	localparam int RUN_BITS  = $clog2(MAX_RUN + 1);

	// fixed port widths
	localparam int IDX_W   = 10;
	localparam int BVAL_W  = 32;
	localparam int POSO_W  = 32;
	localparam int CMP_W   = ((ADDR_BITS > IDX_W) ? ADDR_BITS : IDX_W) + 1;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_GATHER = 2'd1;
	localparam logic [1:0] CMD_END    = 2'd2;
	localparam logic [1:0] CMD_BEGIN  = 2'd3;

	localparam logic [1:0] KIND_POS   = 2'd0;
	localparam logic [1:0] KIND_SPLIT = 2'd1;
	localparam logic [1:0] KIND_ERR   = 2'd2;

	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_INDEX = 3'd1;
	localparam logic [2:0] ERR_DECR  = 3'd2;
	localparam logic [2:0] ERR_LONG  = 3'd3;
	localparam logic [2:0] ERR_SAT   = 3'd4;

	typedef logic [POS_BITS-1:0]  pos_t;
	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_SUB,
		ST_LIM,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		pos_t  wdata;
		logic  re;
		addr_t raddr;
	} mem_req_t;

	typedef struct packed {
		pos_t a;
		pos_t b;
		logic sub;
	} alu_req_t;

	typedef struct packed {
		pos_t sum;
		logic carry;
	} alu_rsp_t;

endpackage

// ===== rtl/rrg_table.sv =====
// ----------------------------------------------------------------------------
// rrg_table
// Split boundary table: one write port and one read port with registered
// read data
// ----------------------------------------------------------------------------
module rrg_table (
	input  logic              clk,
	input  rrg_pkg::mem_req_t req,
	output rrg_pkg::pos_t     rd_data
);
	import rrg_pkg::*;

	pos_t mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

// ===== rtl/rrg_unit.sv =====
// ----------------------------------------------------------------------------
// rrg_unit
// Shared add/subtract unit with carry out; on subtract a clear carry means
// a borrow
// ----------------------------------------------------------------------------
module rrg_unit (
	input  rrg_pkg::alu_req_t req,
	output rrg_pkg::alu_rsp_t rsp
);
	import rrg_pkg::*;

	logic [POS_BITS:0] total;
	pos_t              b_eff;

	assign b_eff = req.sub ? ~req.b : req.b;
	assign total = {1'b0, req.a} + {1'b0, b_eff} + (POS_BITS + 1)'(req.sub);

	assign rsp.sum   = total[POS_BITS-1:0];
	assign rsp.carry = total[POS_BITS];

endmodule

// ===== rtl/rrg_seq.sv =====
// ----------------------------------------------------------------------------
// rrg_seq
// Command sequencer: decodes commands, reads the boundary pair, checks the
// run through the shared unit and steps out positions one per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrg_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               cmd,
	input  logic [rrg_pkg::IDX_W-1:0]  table_addr,
	input  logic [rrg_pkg::BVAL_W-1:0] boundary_value,
	input  logic [rrg_pkg::IDX_W-1:0]  node_index,
	output rrg_pkg::mem_req_t        mem_req,
	input  rrg_pkg::pos_t            rd_data,
	output rrg_pkg::alu_req_t        alu_req,
	input  rrg_pkg::alu_rsp_t        alu_rsp,
	output logic                     strobe,
	output logic [1:0]               kind,
	output logic [rrg_pkg::POSO_W-1:0] position,
	output logic                     last,
	output logic [2:0]               error_code
);
	import rrg_pkg::*;

	state_t state_q, state_d;

	logic                accept;
	logic                begin_acc;
	logic                idx_ok;
	logic                addr_ok;
	logic                len_zero;
	logic [CMP_W-1:0]    node_p1;

	addr_t               node_q;
	pos_t                start_q;
	pos_t                len_q;
	logic [RUN_BITS-1:0] rem_q;
	pos_t                total_q;

	logic                res_vld;
	logic [1:0]          res_kind;
	pos_t                res_pos;
	logic                res_last;
	logic [2:0]          res_code;

	logic                strobe_q;
	logic [1:0]          kind_q;
	pos_t                pos_q;
	logic                last_q;
	logic [2:0]          code_q;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign begin_acc = accept && (cmd == CMD_BEGIN);
	assign node_p1   = CMP_W'(node_index) + CMP_W'(1);
	assign idx_ok    = node_p1 < CMP_W'(TABLE_ENTRIES);
	assign addr_ok   = CMP_W'(table_addr) < CMP_W'(TABLE_ENTRIES);
	assign len_zero  = (len_q == '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_GATHER) && idx_ok) begin
					state_d = ST_RD0;
				end
			end
			ST_RD0: state_d = ST_RD1;
			ST_RD1: state_d = ST_SUB;
			ST_SUB: state_d = alu_rsp.carry ? ST_LIM : ST_IDLE;
			ST_LIM: state_d = alu_rsp.carry ? ST_ADD : ST_IDLE;
			ST_ADD: begin
				if (alu_rsp.carry || len_zero) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (rem_q == RUN_BITS'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory, shared unit and result selection
	always_comb begin
		mem_req.we    = accept && (cmd == CMD_LOAD) && addr_ok;
		mem_req.waddr = ADDR_BITS'(table_addr);
		mem_req.wdata = POS_BITS'(boundary_value);
		mem_req.re    = 1'b0;
		mem_req.raddr = node_q;
		alu_req.a     = '0;
		alu_req.b     = '0;
		alu_req.sub   = 1'b0;
		res_vld       = 1'b0;
		res_kind      = KIND_POS;
		res_pos       = '0;
		res_last      = 1'b1;
		res_code      = ERR_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_BEGIN: begin
							res_vld  = 1'b1;
							res_kind = KIND_SPLIT;
						end
						CMD_END: begin
							res_vld  = 1'b1;
							res_kind = KIND_SPLIT;
							res_pos  = total_q;
						end
						CMD_GATHER: begin
							if (!idx_ok) begin
								res_vld  = 1'b1;
								res_kind = KIND_ERR;
								res_code = ERR_INDEX;
							end
						end
						CMD_LOAD: ;
					endcase
				end
			end
			ST_RD0: begin
				mem_req.re = 1'b1;
			end
			ST_RD1: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = node_q + ADDR_BITS'(1);
			end
			ST_SUB: begin
				// end minus start, borrow means decreasing bounds
				alu_req.a   = rd_data;
				alu_req.b   = start_q;
				alu_req.sub = 1'b1;
				if (!alu_rsp.carry) begin
					res_vld  = 1'b1;
					res_kind = KIND_ERR;
					res_code = ERR_DECR;
				end
			end
			ST_LIM: begin
				alu_req.a   = POS_BITS'(MAX_RUN);
				alu_req.b   = len_q;
				alu_req.sub = 1'b1;
				if (!alu_rsp.carry) begin
					res_vld  = 1'b1;
					res_kind = KIND_ERR;
					res_code = ERR_LONG;
				end
			end
			ST_ADD: begin
				alu_req.a = total_q;
				alu_req.b = len_q;
				if (alu_rsp.carry) begin
					res_vld  = 1'b1;
					res_kind = KIND_ERR;
					res_pos  = '1;
					res_code = ERR_SAT;
				end
			end
			ST_EMIT: begin
				alu_req.a = start_q;
				alu_req.b = POS_BITS'(1);
				res_vld   = 1'b1;
				res_pos   = start_q;
				res_last  = (rem_q == RUN_BITS'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			total_q  <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= res_vld;
			if (begin_acc) begin
				total_q <= '0;
			end else if (state_q == ST_ADD) begin
				// saturate on overflow
				total_q <= alu_rsp.carry ? '1 : alu_rsp.sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			node_q <= ADDR_BITS'(node_index);
		end
		if (state_q == ST_RD1) begin
			start_q <= rd_data;
		end
		if (state_q == ST_SUB) begin
			len_q <= alu_rsp.sum;
		end
		if (state_q == ST_ADD) begin
			rem_q <= len_q[RUN_BITS-1:0];
		end
		if (state_q == ST_EMIT) begin
			start_q <= alu_rsp.sum;
			rem_q   <= rem_q - RUN_BITS'(1);
		end
		if (res_vld) begin
			kind_q <= res_kind;
			pos_q  <= res_pos;
			last_q <= res_last;
			code_q <= res_code;
		end
	end

	assign strobe     = strobe_q;
	assign kind       = kind_q;
	assign position   = POSO_W'(pos_q);
	assign last       = last_q;
	assign error_code = code_q;

	`ASSERT_CLKD(a_emit_gives_result, (state_q == ST_EMIT) |=> strobe_q, "emit cycle without result")
	`ASSERT_CLKD(a_mid_run_from_emit, (strobe_q && !last_q) |-> (kind_q == KIND_POS && $past(state_q == ST_EMIT)), "non-last result outside a run")
	`ASSERT_NEVER(a_emit_count_zero, (state_q == ST_EMIT) && (rem_q == '0), "emit with no positions left")
	`ASSERT_CLKD(a_total_no_drop, (total_q < $past(total_q)) |-> $past(begin_acc), "running total fell without begin")

endmodule

// ===== rtl/ragged_range_gather.sv =====
// ----------------------------------------------------------------------------
// ragged_range_gather
// Gathers position ranges through a loaded split boundary table and emits
// cumulative row splits
// ----------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------
//  command   | start, busy         | cmd, table_addr, boundary_value, node_index
//  result    | strobe (one cycle)  | kind, position, last, error_code
//
//  load, begin, end and index errors are handled on acceptance; busy stays low
//  gather stays busy through two table reads over the single read port, then
//  subtract, limit check and total add in the shared adder, then emits one
//  position per cycle, the position stepped by the same adder; decreasing
//  bounds end after the subtract and an overlong run after the limit check
//  results appear the cycle after they are decided; the receiver cannot stall
//  arst_n clears the sequencer, output strobe and running total; the table
//  holds no reset and must be loaded before it is read
// ----------------------------------------------------------------------------
module ragged_range_gather (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 cmd,
	input  logic [rrg_pkg::IDX_W-1:0]  table_addr,
	input  logic [rrg_pkg::BVAL_W-1:0] boundary_value,
	input  logic [rrg_pkg::IDX_W-1:0]  node_index,
	output logic                       strobe,
	output logic [1:0]                 kind,
	output logic [rrg_pkg::POSO_W-1:0] position,
	output logic                       last,
	output logic [2:0]                 error_code
);
	import rrg_pkg::*;

	mem_req_t mem_req;
	pos_t     rd_data;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	rrg_table u_table (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	rrg_unit u_unit (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	rrg_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.table_addr     (table_addr),
		.boundary_value (boundary_value),
		.node_index     (node_index),
		.mem_req        (mem_req),
		.rd_data        (rd_data),
		.alu_req        (alu_req),
		.alu_rsp        (alu_rsp),
		.strobe         (strobe),
		.kind           (kind),
		.position       (position),
		.last           (last),
		.error_code     (error_code)
	);

endmodule

// ===== bench/ragged_range_gather_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ragged_range_gather_test
// Self-checking bench for the ragged range gather block: a queue of commands
// (directed corner cases, then ragged table segments with gathers and end
// groups, mixed with stray commands) is fed through start/busy with random
// gaps; every transfer is run through a local model of the split table and
// running total, and each strobed result is checked against the oldest owed
// result
// ----------------------------------------------------------------------------
module ragged_range_gather_test;
	import rrg_pkg::*;

	localparam int     CYCLE_LIMIT = 200000;
	localparam int     DRAIN_WAIT  = 100;
	localparam int     ITEM_COUNT  = 370;
	localparam longint POS_TOP     = 64'h0000_0000_FFFF_FFFF;

	typedef struct {
		logic [1:0]        cmd;
		logic [IDX_W-1:0]  addr;
		logic [BVAL_W-1:0] bval;
		logic [IDX_W-1:0]  node;
	} cmd_item_t;

	typedef struct {
		logic [1:0]        kind;
		logic [POSO_W-1:0] pos;
		logic              last;
		logic [2:0]        code;
	} gather_out_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        cmd = CMD_LOAD;
	logic [IDX_W-1:0]  table_addr = '0;
	logic [BVAL_W-1:0] boundary_value = '0;
	logic [IDX_W-1:0]  node_index = '0;
	logic              strobe;
	logic [1:0]        kind;
	logic [POSO_W-1:0] position;
	logic              last;
	logic [2:0]        error_code;

	cmd_item_t   cmd_q[$];
	gather_out_t gather_out_q[$];
	bit          gen_loaded [TABLE_ENTRIES];

	// local copy of the block state
	pos_t        bound_tbl [TABLE_ENTRIES];
	pos_t        split_tally = '0;

	int          err_cnt = 0;
	int          cycle_cnt = 0;
	int          gap_left = 0;
	int          calm_left = 0;
	bit          took_cmd;

	ragged_range_gather dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.table_addr     (table_addr),
		.boundary_value (boundary_value),
		.node_index     (node_index),
		.strobe         (strobe),
		.kind           (kind),
		.position       (position),
		.last           (last),
		.error_code     (error_code)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch, cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
		err_cnt++;
	endtask

	task automatic queue_cmd(input logic [1:0] c, input logic [IDX_W-1:0] a,
			input logic [BVAL_W-1:0] v, input logic [IDX_W-1:0] n);
		cmd_item_t it;
		it.cmd  = c;
		it.addr = a;
		it.bval = v;
		it.node = n;
		cmd_q.push_back(it);
		if (c == CMD_LOAD)
			gen_loaded[a] = 1'b1;
	endtask

	task automatic owe_result(input logic [1:0] k, input pos_t p, input logic l,
			input logic [2:0] c);
		gather_out_t r;
		r.kind = k;
		r.pos  = p;
		r.last = l;
		r.code = c;
		gather_out_q.push_back(r);
	endtask

	// advance the local table and total by one command, owing its results
	task automatic step_gather_unit(input cmd_item_t it);
		pos_t lo;
		pos_t hi;
		pos_t len;
		case (it.cmd)
			CMD_LOAD: begin
				if (int'(it.addr) < TABLE_ENTRIES)
					bound_tbl[it.addr] = it.bval;
			end
			CMD_BEGIN: begin
				split_tally = '0;
				owe_result(KIND_SPLIT, '0, 1'b1, ERR_NONE);
			end
			CMD_END: owe_result(KIND_SPLIT, split_tally, 1'b1, ERR_NONE);
			default: begin
				if (int'(it.node) + 1 >= TABLE_ENTRIES) begin
					owe_result(KIND_ERR, '0, 1'b1, ERR_INDEX);
				end else begin
					lo = bound_tbl[it.node];
					hi = bound_tbl[it.node + IDX_W'(1)];
					len = hi - lo;
					if (hi < lo) begin
						owe_result(KIND_ERR, '0, 1'b1, ERR_DECR);
					end else if (len > pos_t'(MAX_RUN)) begin
						owe_result(KIND_ERR, '0, 1'b1, ERR_LONG);
					end else if (len > ~split_tally) begin
						split_tally = '1;
						owe_result(KIND_ERR, split_tally, 1'b1, ERR_SAT);
					end else begin
						split_tally = split_tally + len;
						for (pos_t k = '0; k < len; k++)
							owe_result(KIND_POS, lo + k, (k + pos_t'(1) == len), ERR_NONE);
					end
				end
			end
		endcase
	endtask

	// driver: start held until the transfer, then a random gap per item, with occasional runs of no gap
	always @(posedge clk) begin
		if (arst_n) begin
			took_cmd = start && !busy;
			if (took_cmd) begin
				step_gather_unit(cmd_q.pop_front());
				if (calm_left > 0) begin
					calm_left--;
					gap_left = 0;
				end else begin
					gap_left = $urandom_range(0, 9);
					if ($urandom_range(0, 15) == 0)
						calm_left = $urandom_range(10, 40);
				end
			end
			if (took_cmd || !start) begin
				if (gap_left == 0 && cmd_q.size() != 0) begin
					start          <= 1'b1;
					cmd            <= cmd_q[0].cmd;
					table_addr     <= cmd_q[0].addr;
					boundary_value <= cmd_q[0].bval;
					node_index     <= cmd_q[0].node;
				end else begin
					start <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end
			end
		end
	end

	// monitor: results cannot be held off, check each strobe
	always @(posedge clk) begin
		gather_out_t want;
		if (arst_n && strobe === 1'b1) begin
			if (gather_out_q.size() == 0) begin
				report_mismatch("result with nothing owed, kind", 32'(kind), '0);
			end else begin
				want = gather_out_q.pop_front();
				if (kind !== want.kind)
					report_mismatch("kind", 32'(kind), 32'(want.kind));
				if (position !== want.pos)
					report_mismatch("position", position, want.pos);
				if (last !== want.last)
					report_mismatch("last", 32'(last), 32'(want.last));
				if (error_code !== want.code)
					report_mismatch("error_code", 32'(error_code), 32'(want.code));
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int          base;
		int          cnt;
		int          reps;
		int          sel;
		int          j;
		int          node_pick;
		bit          up;
		longint      bnd;
		logic [31:0] seg [8];

		// directed: table extremes, every command and each error kind but saturation
		queue_cmd(CMD_BEGIN, '1, '1, '1);
		queue_cmd(CMD_END, '0, '0, '0);
		queue_cmd(CMD_LOAD, 10'd0, 32'd0, '1);
		queue_cmd(CMD_LOAD, 10'd1, 32'd64, '0);
		queue_cmd(CMD_LOAD, 10'd2, 32'd129, '1);
		queue_cmd(CMD_LOAD, 10'd3, 32'd100, '0);
		queue_cmd(CMD_LOAD, 10'd4, 32'd100, '1);
		queue_cmd(CMD_LOAD, 10'd5, 32'd101, '0);
		queue_cmd(CMD_LOAD, 10'd1022, 32'hFFFF_FFC1, '0);
		queue_cmd(CMD_LOAD, 10'd1023, 32'hFFFF_FFFF, '1);
		queue_cmd(CMD_GATHER, '1, '1, 10'd0);     // longest legal run
		queue_cmd(CMD_GATHER, '0, '0, 10'd1);     // one past the longest
		queue_cmd(CMD_GATHER, '1, '0, 10'd2);     // end below start
		queue_cmd(CMD_GATHER, '0, '1, 10'd3);     // empty run, nothing out
		queue_cmd(CMD_GATHER, '1, '1, 10'd4);
		queue_cmd(CMD_GATHER, '0, '0, 10'd1022);  // positions at the top
		queue_cmd(CMD_GATHER, '1, '1, 10'd1023);  // last entry has no upper bound
		queue_cmd(CMD_END, '1, '1, '1);
		queue_cmd(CMD_BEGIN, '0, '0, '0);
		queue_cmd(CMD_END, '0, '1, '0);
		// the total grows by at most MAX_RUN per gather, so saturation
		// lies tens of millions of gathers away and is not reached here

		while (cmd_q.size() < ITEM_COUNT) begin
			sel = $urandom_range(0, 9);
			if (sel <= 5) begin
				// ragged segment: load bounds, gather its rows, close groups
				base = $urandom_range(0, 1016);
				cnt  = $urandom_range(1, 6);
				case ($urandom_range(0, 2))
					0: bnd = $urandom_range(0, 2000);
					1: bnd = $urandom;
					default: bnd = POS_TOP - $urandom_range(0, 600);
				endcase
				for (int k = 0; k <= cnt; k++) begin
					if (k > 0) begin
						j = $urandom_range(0, 19);
						if (j < 14)
							bnd += $urandom_range(0, 12);
						else if (j < 16)
							bnd += MAX_RUN;
						else if (j == 16)
							bnd += MAX_RUN + 1;
						else if (j == 17)
							bnd += $urandom_range(MAX_RUN + 2, 5000);
						else
							bnd -= $urandom_range(1, 40);
					end
					if (bnd < 0)
						bnd = 0;
					if (bnd > POS_TOP)
						bnd = POS_TOP;
					seg[3'(k)] = bnd[31:0];
				end
				if ($urandom_range(0, 1) == 0)
					queue_cmd(CMD_BEGIN, IDX_W'($urandom), $urandom, IDX_W'($urandom));
				up = $urandom_range(0, 1);
				for (int k = 0; k <= cnt; k++) begin
					j = up ? k : cnt - k;
					queue_cmd(CMD_LOAD, IDX_W'(base + j), seg[3'(j)], IDX_W'($urandom));
				end
				reps = cnt + $urandom_range(0, 2);
				for (int k = 0; k < reps; k++) begin
					queue_cmd(CMD_GATHER, IDX_W'($urandom), $urandom,
						IDX_W'(base + $urandom_range(0, cnt - 1)));
					if ($urandom_range(0, 3) == 0)
						queue_cmd(CMD_END, IDX_W'($urandom), $urandom, IDX_W'($urandom));
				end
				queue_cmd(CMD_END, IDX_W'($urandom), $urandom, IDX_W'($urandom));
			end else if (sel == 6) begin
				queue_cmd(CMD_LOAD, IDX_W'($urandom), $urandom, IDX_W'($urandom));
			end else if (sel == 7) begin
				// stray gather on a row whose bounds are both loaded, else on the last entry
				node_pick = TABLE_ENTRIES - 1;
				for (int k = 0; k < 8; k++) begin
					j = $urandom_range(0, TABLE_ENTRIES - 2);
					if (gen_loaded[IDX_W'(j)] && gen_loaded[IDX_W'(j + 1)])
						node_pick = j;
				end
				queue_cmd(CMD_GATHER, IDX_W'($urandom), $urandom, IDX_W'(node_pick));
			end else if (sel == 8) begin
				queue_cmd($urandom_range(0, 1) ? CMD_END : CMD_BEGIN, IDX_W'($urandom),
					$urandom, IDX_W'($urandom));
			end else begin
				queue_cmd(CMD_GATHER, IDX_W'($urandom), $urandom, IDX_W'(TABLE_ENTRIES - 1));
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (cmd_q.size() != 0 || gather_out_q.size() != 0);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
